// ===== rtl/r3cc_pkg.sv =====
// shared constants and types for the rgb 3x3 convolution block
// no dependencies; imported by the top level and its checker

package r3cc_pkg;

	localparam int MAX_WIDTH           = 1024;
	localparam int MAX_HEIGHT          = 1024;
	localparam int COEFF_FRACTION_BITS = 4;

	localparam int COORD_W  = 10;
	localparam int SIZE_W   = 11;
	localparam int CHAN_W   = 8;
	localparam int PIX_W    = 3 * CHAN_W;
	localparam int COEF_W   = 9;
	localparam int KERNEL_W = 3 * COEF_W;
	localparam int LINE_AW  = $clog2(MAX_WIDTH);

	// signed product of a coefficient and a zero-extended channel
	localparam int PROD_W = COEF_W + CHAN_W + 1;
	localparam int COL_W  = PROD_W + 2;
	localparam int SUM_W  = PROD_W + 4;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_LEFT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_CENTER  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_RIGHT   = 3'd4;

	localparam logic [SIZE_W-1:0]   WIDTH_RESET  = SIZE_W'(1024);
	localparam logic [SIZE_W-1:0]   HEIGHT_RESET = SIZE_W'(1024);
	localparam logic [KERNEL_W-1:0] KERNEL_SIDE_RESET   = '0;
	localparam logic [KERNEL_W-1:0] KERNEL_CENTER_RESET = KERNEL_W'(8192);

	typedef logic [PIX_W-1:0] pixel_t;

	typedef struct packed {
		pixel_t two;
		pixel_t one;
	} line_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               interior;
		logic               border;
		pixel_t             pix;
	} meta_t;

endpackage

// ===== rtl/rgb_3x3_convolution_clamp.sv =====
// streaming rgb 3x3 convolution with clamp, top level
// depends on r3cc_pkg; line buffers live in one internal memory

// Takes one pixel request per clock, sustained, when the output side keeps up. A request
// whose pixel is both on the border and completes an interior pixel gives two results and
// holds the output while both leave, which can stall the requests behind it; all others
// give at most one. The two previous rows are kept in one 1024 x 48 memory, read when the
// pixel is accepted and written back as the pixel leaves the first stage, with forwarding
// when consecutive pixels hit the same column. Line buffer contents are undefined after
// reset and are not cleared; the first two rows of every frame give no filtered result and
// fill them.

module rgb_3x3_convolution_clamp
	import r3cc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KERNEL_W-1:0]  cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CHAN_W-1:0]    in_red,
	input  logic [CHAN_W-1:0]    in_green,
	input  logic [CHAN_W-1:0]    in_blue,
	input  logic                 first_pixel,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [COORD_W-1:0]   out_x,
	output logic [COORD_W-1:0]   out_y,
	output logic [CHAN_W-1:0]    out_red,
	output logic [CHAN_W-1:0]    out_green,
	output logic [CHAN_W-1:0]    out_blue,
	output logic                 last_of_run
);

	logic [SIZE_W-1:0]   width_q, height_q;
	logic [KERNEL_W-1:0] kern_q [3];
	logic [COORD_W-1:0]  col_q, row_q;

	logic [SIZE_W-1:0]  w_eff, h_eff, x_inc, y_inc;
	logic [COORD_W-1:0] col_in, row_in;
	logic               accept;
	meta_t              meta_in;

	line_t  line_mem [MAX_WIDTH];
	line_t  rd_s1, fwd_data_s1, cur_line, wr_data;
	logic   fwd_s1;
	meta_t  meta_s1, meta_s2, meta_s3, meta_s4;
	pixel_t win_s2 [9];
	pixel_t win_next [9];

	logic signed [PROD_W-1:0] prod_s3 [3][9];
	logic signed [PROD_W-1:0] prod_c [3][9];
	logic signed [COL_W-1:0]  col_s4 [3][3];
	logic signed [COL_W-1:0]  col_c [3][3];
	logic signed [SUM_W-1:0]  tot_c [3];
	pixel_t                   filt_c;

	logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
	logic s1_adv, s2_adv, s3_adv, s4_adv;
	logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;
	logic out_take, out_last, out_free, s4_any;

	logic               out_int_q, out_brd_q;
	logic [COORD_W-1:0] int_x_q, int_y_q, brd_x_q, brd_y_q;
	pixel_t             int_pix_q, brd_pix_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RESET;
			height_q  <= HEIGHT_RESET;
			kern_q[0] <= KERNEL_SIDE_RESET;
			kern_q[1] <= KERNEL_CENTER_RESET;
			kern_q[2] <= KERNEL_SIDE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:   width_q   <= cfg_data[SIZE_W-1:0];
				CFG_IMAGE_HEIGHT:  height_q  <= cfg_data[SIZE_W-1:0];
				CFG_KERNEL_LEFT:   kern_q[0] <= cfg_data;
				CFG_KERNEL_CENTER: kern_q[1] <= cfg_data;
				CFG_KERNEL_RIGHT:  kern_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake chain
	assign out_last = !(out_int_q && out_brd_q);
	assign out_take = out_v_q && !out_stall;
	assign out_free = !out_v_q || (out_take && out_last);
	assign s4_any   = meta_s4.interior || meta_s4.border;
	assign s4_adv   = s4_v_q && (out_free || !s4_any);
	assign s4_rdy   = !s4_v_q || s4_adv;
	assign s3_adv   = s3_v_q && s4_rdy;
	assign s3_rdy   = !s3_v_q || s3_adv;
	assign s2_adv   = s2_v_q && s3_rdy;
	assign s2_rdy   = !s2_v_q || s2_adv;
	assign s1_adv   = s1_v_q && s2_rdy;
	assign s1_rdy   = !s1_v_q || s1_adv;
	assign in_stall = !s1_rdy;
	assign accept   = in_valid && s1_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
			s3_v_q <= 1'b0;
			s4_v_q <= 1'b0;
		end else begin
			if (s1_rdy) s1_v_q <= in_valid;
			if (s2_rdy) s2_v_q <= s1_adv;
			if (s3_rdy) s3_v_q <= s2_adv;
			if (s4_rdy) s4_v_q <= s3_adv;
		end
	end

	// position of the arriving pixel
	always_comb begin
		w_eff = (width_q == '0) ? SIZE_W'(1) :
			(width_q > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_q;
		h_eff = (height_q == '0) ? SIZE_W'(1) :
			(height_q > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_q;
		col_in = (first_pixel || {1'b0, col_q} >= w_eff) ? '0 : col_q;
		row_in = (first_pixel || {1'b0, row_q} >= h_eff) ? '0 : row_q;
		x_inc  = {1'b0, col_in} + SIZE_W'(1);
		y_inc  = {1'b0, row_in} + SIZE_W'(1);
		meta_in.x        = col_in;
		meta_in.y        = row_in;
		meta_in.interior = (col_in >= COORD_W'(2)) && (row_in >= COORD_W'(2));
		meta_in.border   = (col_in == '0) || (row_in == '0) ||
			(x_inc == w_eff) || (y_inc == h_eff);
		meta_in.pix      = {in_blue, in_green, in_red};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (x_inc >= w_eff) begin
				col_q <= '0;
				row_q <= (y_inc >= h_eff) ? '0 : y_inc[COORD_W-1:0];
			end else begin
				col_q <= x_inc[COORD_W-1:0];
				row_q <= row_in;
			end
		end
	end

	// line buffer read at accept, write back when the pixel leaves stage 1
	assign cur_line    = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign wr_data.two = cur_line.one;
	assign wr_data.one = meta_s1.pix;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= line_mem[col_in[LINE_AW-1:0]];
		end
		if (s1_adv) begin
			line_mem[meta_s1.x[LINE_AW-1:0]] <= wr_data;
		end
	end

	// same column written in the cycle it is read: take the new entry
	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1     <= meta_in;
			fwd_s1      <= s1_adv && (meta_s1.x == col_in);
			fwd_data_s1 <= wr_data;
		end
	end

	// window shifts by one column per pixel
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			win_next[i] = win_s2[i+3];
		end
		win_next[6] = cur_line.two;
		win_next[7] = cur_line.one;
		win_next[8] = meta_s1.pix;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			win_s2  <= win_next;
			meta_s2 <= meta_s1;
		end
	end

	// products: window row 0 is two rows above, coefficient slot 2
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					prod_c[ch][c*3+r] = PROD_W'(
						$signed(kern_q[c][COEF_W*(2-r) +: COEF_W]) *
						$signed({1'b0, win_s2[c*3+r][CHAN_W*ch +: CHAN_W]}));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			prod_s3 <= prod_c;
			meta_s3 <= meta_s2;
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int c = 0; c < 3; c++) begin
				col_c[ch][c] = COL_W'(prod_s3[ch][c*3]) + COL_W'(prod_s3[ch][c*3+1]) +
					COL_W'(prod_s3[ch][c*3+2]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s3_adv) begin
			col_s4  <= col_c;
			meta_s4 <= meta_s3;
		end
	end

	// negative sums clamp to zero and large ones to 255, so truncation reduces to a shift
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			tot_c[ch] = SUM_W'(col_s4[ch][0]) + SUM_W'(col_s4[ch][1]) +
				SUM_W'(col_s4[ch][2]);
			if (tot_c[ch] < 0) begin
				filt_c[CHAN_W*ch +: CHAN_W] = '0;
			end else if ((tot_c[ch] >>> COEFF_FRACTION_BITS) > SUM_W'(255)) begin
				filt_c[CHAN_W*ch +: CHAN_W] = '1;
			end else begin
				filt_c[CHAN_W*ch +: CHAN_W] =
					tot_c[ch][COEFF_FRACTION_BITS +: CHAN_W];
			end
		end
	end

	// output stage holds up to two results of one request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			out_int_q <= 1'b0;
			out_brd_q <= 1'b0;
		end else if (s4_adv && s4_any) begin
			out_v_q   <= 1'b1;
			out_int_q <= meta_s4.interior;
			out_brd_q <= meta_s4.border;
		end else if (out_take) begin
			if (out_last) begin
				out_v_q <= 1'b0;
			end else begin
				out_int_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s4_adv && s4_any) begin
			int_x_q   <= meta_s4.x - COORD_W'(1);
			int_y_q   <= meta_s4.y - COORD_W'(1);
			int_pix_q <= filt_c;
			brd_x_q   <= meta_s4.x;
			brd_y_q   <= meta_s4.y;
			brd_pix_q <= meta_s4.pix;
		end
	end

	assign out_valid   = out_v_q;
	assign last_of_run = out_last;
	assign out_x       = out_int_q ? int_x_q : brd_x_q;
	assign out_y       = out_int_q ? int_y_q : brd_y_q;
	assign out_red     = out_int_q ? int_pix_q[0 +: CHAN_W] : brd_pix_q[0 +: CHAN_W];
	assign out_green   = out_int_q ? int_pix_q[CHAN_W +: CHAN_W] :
		brd_pix_q[CHAN_W +: CHAN_W];
	assign out_blue    = out_int_q ? int_pix_q[2*CHAN_W +: CHAN_W] :
		brd_pix_q[2*CHAN_W +: CHAN_W];

endmodule

// ===== rtl/r3cc_checker.sv =====
// port-level checks for the rgb 3x3 convolution block, bound to its top level
// depends on r3cc_pkg and rgb_3x3_convolution_clamp

module r3cc_checker
	import r3cc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [CHAN_W-1:0]    in_red,
	input logic [CHAN_W-1:0]    in_green,
	input logic [CHAN_W-1:0]    in_blue,
	input logic                 first_pixel,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [COORD_W-1:0]   out_x,
	input logic [COORD_W-1:0]   out_y,
	input logic [CHAN_W-1:0]    out_red,
	input logic [CHAN_W-1:0]    out_green,
	input logic [CHAN_W-1:0]    out_blue,
	input logic                 last_of_run
);

	// a stalled request holds
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_red) && $stable(in_green) &&
			$stable(in_blue) && $stable(first_pixel))
		else $error("stalled request changed");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y) &&
			$stable(out_red) && $stable(out_green) && $stable(out_blue) &&
			$stable(last_of_run))
		else $error("stalled result changed");

	// the border pixel follows its interior pixel at once, one step down and right
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid &&
			out_x == $past(out_x) + COORD_W'(1) && out_y == $past(out_y) + COORD_W'(1))
		else $error("second result of a request is missing or misplaced");

	// a filtered pixel followed by a border result never lies on the first row or column
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> out_x != '0 && out_y != '0)
		else $error("interior result on the border");

	// nothing leaves right after reset
	assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present after reset");

endmodule

bind rgb_3x3_convolution_clamp r3cc_checker u_r3cc_checker (.*);
